### rtl/ymhp_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ymhp_pkg
// Shared types, codes and constants of the YM music file header parser.
// ============================================================================
package ymhp_pkg;

    // Field widths of the channels.
    localparam int STATUS_W    = 4;
    localparam int VARIANT_W   = 3;
    localparam int FRAME_W     = 21;
    localparam int RATE_W      = 16;
    localparam int OFFSET_W    = 25;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 21;

    // Verdict codes, in the order in which the checks are made, but for ST_OVERFLOW, which is checked first.
    localparam logic [STATUS_W-1:0] ST_OK           = 4'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT        = 4'd1;
    localparam logic [STATUS_W-1:0] ST_MAGIC        = 4'd2;
    localparam logic [STATUS_W-1:0] ST_YM3_LENGTH   = 4'd3;
    localparam logic [STATUS_W-1:0] ST_SIGNATURE    = 4'd4;
    localparam logic [STATUS_W-1:0] ST_DRUMS        = 4'd5;
    localparam logic [STATUS_W-1:0] ST_FRAMES       = 4'd6;
    localparam logic [STATUS_W-1:0] ST_RATE         = 4'd7;
    localparam logic [STATUS_W-1:0] ST_INTERLEAVE   = 4'd8;
    localparam logic [STATUS_W-1:0] ST_STRINGS_CUT  = 4'd9;
    localparam logic [STATUS_W-1:0] ST_DATA_SHORT   = 4'd10;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW     = 4'd11;

    // Format versions.
    localparam logic [VARIANT_W-1:0] VAR_NONE = 3'd0;
    localparam logic [VARIANT_W-1:0] VAR_YM3  = 3'd3;
    localparam logic [VARIANT_W-1:0] VAR_YM5  = 3'd5;
    localparam logic [VARIANT_W-1:0] VAR_YM6  = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_FRAMES = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_RATE   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RATE   = 2'd2;

    localparam logic [FRAME_W-1:0] MAX_FRAMES_RESET = 21'd1048576;
    localparam logic [RATE_W-1:0]  MIN_RATE_RESET   = 16'd25;
    localparam logic [RATE_W-1:0]  MAX_RATE_RESET   = 16'd1000;

    // Fixed answers for a YM3 file.
    localparam logic [RATE_W-1:0]   YM3_RATE   = 16'd50;
    localparam logic [OFFSET_W-1:0] YM3_OFFSET = 25'd4;

    // Magic characters.
    localparam logic [7:0] CHR_Y    = 8'h59;
    localparam logic [7:0] CHR_M    = 8'h4D;
    localparam logic [7:0] CHR_3    = 8'h33;
    localparam logic [7:0] CHR_5    = 8'h35;
    localparam logic [7:0] CHR_6    = 8'h36;
    localparam logic [7:0] CHR_BANG = 8'h21;

    // Byte positions of the YM5/YM6 header fields.
    localparam int MAGIC_LAST    = 3;
    localparam int SIG_FIRST     = 4;
    localparam int SIG_END       = 12;
    localparam int FRAMES_END    = 16;
    localparam int ATTR_LOW      = 19;
    localparam int DRUMS_FIRST   = 20;
    localparam int DRUMS_END     = 22;
    localparam int RATE_FIRST    = 26;
    localparam int RATE_END      = 28;
    localparam int EXTRA_FIRST   = 32;
    localparam int HDR_LEN       = 34;
    localparam int MIN_LEN       = 4;
    localparam int STRING_COUNT  = 3;

    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_YM3     = 3'd1,
        PH_HEADER  = 3'd2,
        PH_EXTRA   = 3'd3,
        PH_STRINGS = 3'd4,
        PH_DATA    = 3'd5,
        PH_UNKNOWN = 3'd6
    } phase_t;

    typedef struct packed {
        logic [FRAME_W-1:0] max_frames;
        logic [RATE_W-1:0]  min_rate;
        logic [RATE_W-1:0]  max_rate;
    } cfg_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [VARIANT_W-1:0] variant;
        logic [FRAME_W-1:0]   frame_total;
        logic [RATE_W-1:0]    frame_rate;
        logic [OFFSET_W-1:0]  data_offset;
    } result_t;

    // The eight signature characters "LeOnArD!".
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] ch;
        unique case (idx)
            3'd0: ch = 8'h4C;
            3'd1: ch = 8'h65;
            3'd2: ch = 8'h4F;
            3'd3: ch = 8'h6E;
            3'd4: ch = 8'h41;
            3'd5: ch = 8'h72;
            3'd6: ch = 8'h44;
            3'd7: ch = 8'h21;
        endcase
        return ch;
    endfunction

endpackage

### rtl/ymhp_cfg_regs.sv
`timescale 1ns / 1ps
// ============================================================================
// ymhp_cfg_regs
// Configuration registers: frame limit and player rate window.
// ============================================================================
module ymhp_cfg_regs
    import ymhp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Writes to an index beyond the list are taken and ignored.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_MAX_FRAMES: cfg_next.max_frames = cfg_data[FRAME_W-1:0];
                CFG_MIN_RATE:   cfg_next.min_rate   = cfg_data[RATE_W-1:0];
                CFG_MAX_RATE:   cfg_next.max_rate   = cfg_data[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_frames <= MAX_FRAMES_RESET;
            cfg_reg.min_rate   <= MIN_RATE_RESET;
            cfg_reg.max_rate   <= MAX_RATE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/ymhp_in_stage.sv
`timescale 1ns / 1ps
// ============================================================================
// ymhp_in_stage
// Input register that holds one file byte until the parser takes it.
// ============================================================================
module ymhp_in_stage
    import ymhp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] data_byte,
    output logic       last_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       last_reg;

    // The register refills in the same cycle that the parser empties it.
    assign s_ready    = !valid_reg || advance;
    assign valid_next = (s_valid && s_ready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data_byte;
            last_reg <= s_last_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign data_byte  = data_reg;
    assign last_byte  = last_reg;

endmodule

### rtl/ymhp_parse_core.sv
`timescale 1ns / 1ps
// ============================================================================
// ymhp_parse_core
// Parser state, per-byte update and the end-of-file verdict.
// ============================================================================
module ymhp_parse_core
    import ymhp_pkg::*;
#(
    parameter int POSITION_BITS  = 25,
    parameter int YM3_MAX_DATA   = 1048576,
    parameter int REGS_PER_FRAME = 14
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  cfg_t       cfg,
    output result_t    verdict
);

    localparam int PB  = POSITION_BITS;
    localparam int CW  = ((PB > 25) ? PB : 25) + 2;
    localparam int GPW = $clog2(REGS_PER_FRAME);
    localparam int GCW = $clog2(YM3_MAX_DATA / REGS_PER_FRAME + 1);
    localparam int FBW = FRAME_W + $clog2(REGS_PER_FRAME + 1);

    logic [PB-1:0]        pos_reg,        pos_next;
    phase_t               phase_reg,      phase_next;
    logic [VARIANT_W-1:0] format_reg,     format_next;
    logic                 match_reg,      match_next;
    logic [31:0]          frames_reg,     frames_next;
    logic                 interleave_reg, interleave_next;
    logic [15:0]          drum_reg,       drum_next;
    logic [15:0]          rate_reg,       rate_next;
    logic [15:0]          extra_reg,      extra_next;
    logic [1:0]           strings_reg,    strings_next;
    logic [PB-1:0]        start_reg,      start_next;
    logic [GPW-1:0]       gphase_reg,     gphase_next;
    logic [GCW-1:0]       gcount_reg,     gcount_next;
    logic                 overflow_reg,   overflow_next;
    logic [FBW-1:0]       fbytes_reg,     fbytes_next;

    logic [CW-1:0]        pos_w;
    logic [CW-1:0]        len_w;
    logic [CW-1:0]        end_w;
    logic [STATUS_W-1:0]  status;

    assign pos_w = CW'(pos_reg);
    assign len_w = pos_w + CW'(1);
    assign end_w = CW'(start_next) + CW'(fbytes_reg);

    always_comb begin
        pos_next        = pos_reg;
        phase_next      = phase_reg;
        format_next     = format_reg;
        match_next      = match_reg;
        frames_next     = frames_reg;
        interleave_next = interleave_reg;
        drum_next       = drum_reg;
        rate_next       = rate_reg;
        extra_next      = extra_reg;
        strings_next    = strings_reg;
        start_next      = start_reg;
        gphase_next     = gphase_reg;
        gcount_next     = gcount_reg;
        overflow_next   = overflow_reg;
        fbytes_next     = fbytes_reg;

        // The position holds at its top value and marks the file as overflowed.
        if (pos_reg == {PB{1'b1}}) begin
            overflow_next = 1'b1;
        end else begin
            pos_next = pos_reg + 1'b1;
        end

        unique case (phase_reg)
            PH_MAGIC: begin
                if (pos_reg == PB'(0) && data_byte != CHR_Y) begin
                    match_next = 1'b0;
                end
                if (pos_reg == PB'(1) && data_byte != CHR_M) begin
                    match_next = 1'b0;
                end
                if (pos_reg == PB'(2)) begin
                    priority if (data_byte == CHR_3) begin
                        format_next = VAR_YM3;
                    end else if (data_byte == CHR_5) begin
                        format_next = VAR_YM5;
                    end else if (data_byte == CHR_6) begin
                        format_next = VAR_YM6;
                    end else begin
                        match_next = 1'b0;
                    end
                end
                if (pos_reg == PB'(MAGIC_LAST)) begin
                    if (!match_reg || data_byte != CHR_BANG) begin
                        phase_next = PH_UNKNOWN;
                    end else if (format_reg == VAR_YM3) begin
                        phase_next = PH_YM3;
                    end else begin
                        phase_next = PH_HEADER;
                    end
                    match_next = 1'b1;
                end
            end
            PH_YM3: begin
                // Frames are counted as whole groups of register bytes.
                if (gphase_reg == GPW'(REGS_PER_FRAME - 1)) begin
                    gphase_next = '0;
                    gcount_next = gcount_reg + 1'b1;
                end else begin
                    gphase_next = gphase_reg + 1'b1;
                end
            end
            PH_HEADER: begin
                if (pos_reg >= PB'(SIG_FIRST) && pos_reg < PB'(SIG_END)
                        && data_byte != sig_byte(3'(pos_reg[2:0] - 3'd4))) begin
                    match_next = 1'b0;
                end
                if (pos_reg >= PB'(SIG_END) && pos_reg < PB'(FRAMES_END)) begin
                    frames_next = {frames_reg[23:0], data_byte};
                end
                if (pos_reg == PB'(ATTR_LOW)) begin
                    interleave_next = data_byte[0];
                end
                if (pos_reg >= PB'(DRUMS_FIRST) && pos_reg < PB'(DRUMS_END)) begin
                    drum_next = {drum_reg[7:0], data_byte};
                end
                if (pos_reg >= PB'(RATE_FIRST) && pos_reg < PB'(RATE_END)) begin
                    rate_next = {rate_reg[7:0], data_byte};
                end
                if (pos_reg >= PB'(EXTRA_FIRST) && pos_reg < PB'(HDR_LEN)) begin
                    extra_next = {extra_reg[7:0], data_byte};
                end
                if (pos_reg == PB'(HDR_LEN - 1)) begin
                    phase_next  = (extra_next == 16'd0) ? PH_STRINGS : PH_EXTRA;
                    // Register byte count, ready long before the data phase.
                    fbytes_next = FBW'(frames_reg[FRAME_W-1:0]) * FBW'(REGS_PER_FRAME);
                end
            end
            PH_EXTRA: begin
                if (pos_w >= CW'(HDR_LEN - 1) + CW'(extra_reg)) begin
                    phase_next = PH_STRINGS;
                end
            end
            PH_STRINGS: begin
                if (data_byte == 8'd0) begin
                    strings_next = strings_reg + 1'b1;
                    if (strings_reg == 2'(STRING_COUNT - 1)) begin
                        start_next = pos_reg + 1'b1;
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA, PH_UNKNOWN: ;
            default: ;
        endcase
    end

    // The verdict looks at the state as it stands after this byte.
    always_comb begin
        priority if (overflow_next) begin
            status = ST_OVERFLOW;
        end else if (len_w < CW'(MIN_LEN)) begin
            status = ST_SHORT;
        end else if (phase_next == PH_UNKNOWN) begin
            status = ST_MAGIC;
        end else if (phase_next == PH_YM3) begin
            if (pos_reg == PB'(MAGIC_LAST) || gphase_next != '0
                    || len_w > CW'(YM3_MAX_DATA + MIN_LEN)) begin
                status = ST_YM3_LENGTH;
            end else begin
                status = ST_OK;
            end
        end else if (len_w < CW'(HDR_LEN)) begin
            status = ST_SHORT;
        end else if (!match_next) begin
            status = ST_SIGNATURE;
        end else if (drum_next != 16'd0) begin
            status = ST_DRUMS;
        end else if (frames_next == 32'd0 || frames_next > 32'(cfg.max_frames)) begin
            status = ST_FRAMES;
        end else if (rate_next < cfg.min_rate || rate_next > cfg.max_rate) begin
            status = ST_RATE;
        end else if (!interleave_next) begin
            status = ST_INTERLEAVE;
        end else if (phase_next != PH_DATA) begin
            status = ST_STRINGS_CUT;
        end else if (end_w > len_w) begin
            status = ST_DATA_SHORT;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        verdict        = '0;
        verdict.status = status;
        if (status == ST_OK) begin
            if (phase_next == PH_YM3) begin
                verdict.variant     = VAR_YM3;
                verdict.frame_total = FRAME_W'(gcount_next);
                verdict.frame_rate  = YM3_RATE;
                verdict.data_offset = YM3_OFFSET;
            end else begin
                verdict.variant     = format_next;
                verdict.frame_total = frames_next[FRAME_W-1:0];
                verdict.frame_rate  = rate_next;
                verdict.data_offset = OFFSET_W'(start_next);
            end
        end
    end

    // The last byte of a file returns the parser to its reset state.
    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && last_byte)) begin
            pos_reg        <= '0;
            phase_reg      <= PH_MAGIC;
            format_reg     <= VAR_NONE;
            match_reg      <= 1'b1;
            frames_reg     <= '0;
            interleave_reg <= 1'b0;
            drum_reg       <= '0;
            rate_reg       <= '0;
            extra_reg      <= '0;
            strings_reg    <= '0;
            start_reg      <= '0;
            gphase_reg     <= '0;
            gcount_reg     <= '0;
            overflow_reg   <= 1'b0;
            fbytes_reg     <= '0;
        end else if (advance) begin
            pos_reg        <= pos_next;
            phase_reg      <= phase_next;
            format_reg     <= format_next;
            match_reg      <= match_next;
            frames_reg     <= frames_next;
            interleave_reg <= interleave_next;
            drum_reg       <= drum_next;
            rate_reg       <= rate_next;
            extra_reg      <= extra_next;
            strings_reg    <= strings_next;
            start_reg      <= start_next;
            gphase_reg     <= gphase_next;
            gcount_reg     <= gcount_next;
            overflow_reg   <= overflow_next;
            fbytes_reg     <= fbytes_next;
        end
    end

endmodule

### rtl/ymhp_out_stage.sv
`timescale 1ns / 1ps
// ============================================================================
// ymhp_out_stage
// Result register that holds one verdict until the receiver takes it.
// ============================================================================
module ymhp_out_stage
    import ymhp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  result_t              verdict,
    output logic                 can_load,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [STATUS_W-1:0]  m_status,
    output logic [VARIANT_W-1:0] m_variant,
    output logic [FRAME_W-1:0]   m_frame_total,
    output logic [RATE_W-1:0]    m_frame_rate,
    output logic [OFFSET_W-1:0]  m_data_offset
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load || (valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= verdict;
        end
    end

    assign m_valid       = valid_reg;
    assign m_status      = result_reg.status;
    assign m_variant     = result_reg.variant;
    assign m_frame_total = result_reg.frame_total;
    assign m_frame_rate  = result_reg.frame_rate;
    assign m_data_offset = result_reg.data_offset;

endmodule

### rtl/ym_music_header_parser.sv
`timescale 1ns / 1ps
// ============================================================================
// ym_music_header_parser
// Streaming header checker for YM3, YM5 and YM6 chiptune files.
// ============================================================================
// The s_ channel carries a file one byte per transaction, in file order, with
// s_last_byte high on the final byte. Each file gives exactly one transaction
// on the m_ channel: a status code (zero when the file is accepted) and, for an
// accepted file, its format version, frame count, player rate and the offset
// of the register streams. Bytes before the last produce no result.
// The cfg_ channel writes the frame limit and the player rate window; cfg_ready
// is always high and writes are meant to happen while no file is in flight.
// Throughput is one byte per clock: the input register hands a byte to the
// parser, which updates its state and loads the result register on the last
// byte. The last byte passes the input register, then the result register,
// before its verdict appears on m_valid. While a result waits on m_ready,
// further non-final bytes keep flowing; only a next final byte waits until the
// result register frees, and the input then holds one byte before s_ready drops.
// Reset (aresetn low, synchronous) empties both registers, restores the
// configuration defaults and puts the parser at the start of a file. After
// every final byte the parser starts over, so files may follow back to back.
// ============================================================================
module ym_music_header_parser
    import ymhp_pkg::*;
#(
    parameter int POSITION_BITS  = 25,
    parameter int YM3_MAX_DATA   = 1048576,
    parameter int REGS_PER_FRAME = 14
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_data_byte,
    input  logic                   s_last_byte,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [STATUS_W-1:0]    m_status,
    output logic [VARIANT_W-1:0]   m_variant,
    output logic [FRAME_W-1:0]     m_frame_total,
    output logic [RATE_W-1:0]      m_frame_rate,
    output logic [OFFSET_W-1:0]    m_data_offset,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t       cfg;
    result_t    verdict;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       can_load;
    logic       advance;

    // A byte moves into the parser unless it is the final byte and the
    // previous verdict has not been taken yet.
    assign advance = byte_valid && (!last_byte || can_load);

    ymhp_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ymhp_in_stage u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .advance     (advance),
        .byte_valid  (byte_valid),
        .data_byte   (data_byte),
        .last_byte   (last_byte)
    );

    ymhp_parse_core #(
        .POSITION_BITS  (POSITION_BITS),
        .YM3_MAX_DATA   (YM3_MAX_DATA),
        .REGS_PER_FRAME (REGS_PER_FRAME)
    ) u_parse_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .cfg       (cfg),
        .verdict   (verdict)
    );

    ymhp_out_stage u_out_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (advance && last_byte),
        .verdict       (verdict),
        .can_load      (can_load),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_variant     (m_variant),
        .m_frame_total (m_frame_total),
        .m_frame_rate  (m_frame_rate),
        .m_data_offset (m_data_offset)
    );

endmodule

### rtl/ymhp_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// ymhp_checker
// Port-level checks of the YM header parser, bound to its top level.
// ============================================================================
module ymhp_checker
    import ymhp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [STATUS_W-1:0]  m_status,
    input logic [VARIANT_W-1:0] m_variant,
    input logic [FRAME_W-1:0]   m_frame_total,
    input logic [RATE_W-1:0]    m_frame_rate,
    input logic [OFFSET_W-1:0]  m_data_offset
);

    // A stalled result keeps its verdict.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_variant))
        else $error("result changed while stalled");

    // A rejected file reports no header fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_variant == VAR_NONE
            && m_frame_total == '0 && m_frame_rate == '0 && m_data_offset == '0)
        else $error("rejected file carries header fields");

    // An accepted file names one of the three known versions.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OK |-> m_variant == VAR_YM3
            || m_variant == VAR_YM5 || m_variant == VAR_YM6)
        else $error("accepted file with unknown version");

    // A YM3 file always plays at the fixed rate from the fixed offset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OK && m_variant == VAR_YM3
            |-> m_frame_rate == YM3_RATE && m_data_offset == YM3_OFFSET
            && m_frame_total != '0)
        else $error("YM3 result fields wrong");

endmodule

bind ym_music_header_parser ymhp_checker u_ymhp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_variant     (m_variant),
    .m_frame_total (m_frame_total),
    .m_frame_rate  (m_frame_rate),
    .m_data_offset (m_data_offset)
);
